// ===== rtl/ffud_pkg.sv =====
// shared types and constants for the form field url decoder
// word structs, character codes, escape phases, register indexes, hex helper
// no dependencies
package ffud_pkg;

  // input word: one raw byte or an end-of-line mark
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_word_t;

  // output word: optional decoded byte and field end mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
  } out_word_t;

  // escape decoding phase
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HIGH = 2'd2
  } esc_phase_t;

  // configuration register indexes
  localparam logic REG_STOP_CHAR = 1'b0;
  localparam logic REG_MAX_LEN   = 1'b1;

  localparam int CFG_DATA_BITS = 10;
  localparam int MAX_LEN_BITS  = 10;

  localparam logic [7:0] STOP_CHAR_RESET = 8'd38;
  localparam logic [9:0] MAX_LEN_RESET   = 10'd255;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] HEX_TEN    = 8'd10;
  localparam int         NIBBLE     = 4;

  // lenient hex digit value, anything outside 0-9 and A-F maps as c - 'a' + 10
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = c - CH_UPPER_A + HEX_TEN;
    end else begin
      v = c - CH_LOWER_A + HEX_TEN;
    end
    return v;
  endfunction

endpackage

// ===== rtl/form_field_url_decoder.sv =====
// Form field url decoder: splits a form-urlencoded byte stream into fields
// and percent-decodes each one (plus as space), one result word per input word.
// Input channel item_valid/item_ready/item carries a raw byte or an
// end-of-line mark; output channel result_valid/result_ready/result carries
// an optional decoded byte and a field end flag.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 stop character, 1 max kept length); write only while idle.
// An accepted word passes the input register and then the output register,
// where result_valid rises. Throughput: one word per cycle while the
// receiver keeps result_ready high.
// Reset clears field state, restores stop '&' and length 255, and empties
// both registers. When the receiver stalls, the output register holds its
// word, the input register takes one more word if empty, then item_ready drops.
// Depends on ffud_pkg, ffud_core, ffud_out_reg.
module form_field_url_decoder
  import ffud_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  in_word_t                 item,
  output logic                     result_valid,
  input  logic                     result_ready,
  output out_word_t                result
);

  logic [7:0]              stop_char;
  logic [MAX_LEN_BITS-1:0] max_len;
  logic                    res_load;
  logic                    res_ready;
  out_word_t               res_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_char <= STOP_CHAR_RESET;
      max_len   <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STOP_CHAR: stop_char <= cfg_data[7:0];
        REG_MAX_LEN:   max_len   <= cfg_data[MAX_LEN_BITS-1:0];
        default:       stop_char <= stop_char;
      endcase
    end
  end

  // decode stage
  ffud_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .stop_char (stop_char),
    .max_len   (max_len),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_load  (res_load),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // result register
  ffud_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (res_load),
    .load_ready  (res_ready),
    .word        (res_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ===== rtl/ffud_core.sv =====
// input register, per-field state and single pass decode of one byte
// depends on ffud_pkg
module ffud_core
  import ffud_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              stop_char,
  input  logic [MAX_LEN_BITS-1:0] max_len,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  in_word_t                item,
  output logic                    res_load,
  input  logic                    res_ready,
  output out_word_t               res_word
);

  localparam int LIM_BITS = (COUNT_BITS > MAX_LEN_BITS) ? COUNT_BITS : MAX_LEN_BITS;
  localparam logic [LIM_BITS-1:0] CAP = LIM_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  // input register
  in_word_t hold;
  logic     hold_valid;

  // field state
  esc_phase_t            escape_phase, escape_phase_next;
  logic [7:0]            partial_byte, partial_byte_next;
  logic [COUNT_BITS-1:0] raw_count, raw_count_next;
  logic                  field_terminated, field_terminated_next;

  logic                  fire;
  logic                  is_end;
  logic                  keep;
  logic [LIM_BITS-1:0]   limit;
  logic [LIM_BITS-1:0]   max_len_ext;
  logic [LIM_BITS-1:0]   count_ext;
  logic [7:0]            ch;
  logic [7:0]            hv;
  logic [7:0]            sum;

  assign fire       = hold_valid && res_ready;
  assign item_ready = !hold_valid || res_ready;
  assign res_load   = fire;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold <= item;
    end
  end

  // kept-byte limit, capped by the counter width
  assign max_len_ext = LIM_BITS'(max_len);
  assign count_ext   = LIM_BITS'(raw_count);
  assign limit       = (max_len_ext < CAP) ? max_len_ext : CAP;
  assign keep        = count_ext < limit;

  assign is_end = hold.end_of_line || hold.char_in == 8'd0 || hold.char_in == stop_char;
  assign ch     = (hold.char_in == CH_PLUS) ? CH_SPACE : hold.char_in;
  assign hv     = hex_value(ch);
  assign sum    = partial_byte + hv;

  // decode and next state
  always_comb begin
    escape_phase_next     = escape_phase;
    partial_byte_next     = partial_byte;
    raw_count_next        = raw_count;
    field_terminated_next = field_terminated;
    res_word              = '0;
    if (is_end) begin
      res_word.field_end = 1'b1;
      if (!field_terminated) begin
        if (escape_phase == ESC_PCT) begin
          res_word.out_byte   = CH_PERCENT;
          res_word.byte_valid = 1'b1;
        end else if (escape_phase == ESC_HIGH && partial_byte != 8'd0) begin
          res_word.out_byte   = partial_byte;
          res_word.byte_valid = 1'b1;
        end
      end
      escape_phase_next     = ESC_NONE;
      partial_byte_next     = 8'd0;
      raw_count_next        = '0;
      field_terminated_next = 1'b0;
    end else if (keep) begin
      raw_count_next = raw_count + 1'b1;
      if (!field_terminated) begin
        case (escape_phase)
          ESC_NONE: begin
            if (ch == CH_PERCENT) begin
              escape_phase_next = ESC_PCT;
            end else begin
              res_word.out_byte   = ch;
              res_word.byte_valid = 1'b1;
            end
          end
          ESC_PCT: begin
            partial_byte_next = {hv[NIBBLE-1:0], {NIBBLE{1'b0}}};
            escape_phase_next = ESC_HIGH;
          end
          default: begin
            escape_phase_next = ESC_NONE;
            partial_byte_next = 8'd0;
            if (sum == 8'd0) begin
              field_terminated_next = 1'b1;
            end else begin
              res_word.out_byte   = sum;
              res_word.byte_valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // state update when a word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase     <= ESC_NONE;
      partial_byte     <= 8'd0;
      raw_count        <= '0;
      field_terminated <= 1'b0;
    end else if (fire) begin
      escape_phase     <= escape_phase_next;
      partial_byte     <= partial_byte_next;
      raw_count        <= raw_count_next;
      field_terminated <= field_terminated_next;
    end
  end

endmodule

// ===== rtl/ffud_out_reg.sv =====
// output register holding one decoded word until the receiver takes it
// depends on ffud_pkg
module ffud_out_reg
  import ffud_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  output logic      load_ready,
  input  out_word_t word,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  assign load_ready = !result_valid || result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_ready && load) begin
      result <= word;
    end
  end

endmodule

// ===== test/ffud_decode_checker.sv =====
// decode checker for the form field url decoder: follows register writes,
// predicts every result word from the accepted input words and compares them
// depends on ffud_pkg
module ffud_decode_checker
  import ffud_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     item_valid,
  input  logic                     item_ready,
  input  in_word_t                 item,
  input  logic                     result_valid,
  input  logic                     result_ready,
  input  out_word_t                result,
  output int                       mismatches,
  output int                       pending,
  output int                       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         KEEP_CAP     = (1 << COUNT_BITS) - 1;
  localparam int         REPORT_LINES = 30;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // mirrored registers and field state
  logic [7:0]              stop_cfg;
  logic [MAX_LEN_BITS-1:0] max_len_cfg;
  esc_phase_t              esc_phase;
  logic [7:0]              high_nibble;
  logic [COUNT_BITS-1:0]   kept_count;
  logic                    field_dead;

  // predicted result words, oldest first
  out_word_t decoded_q[$];
  out_word_t want;

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
  end

  // lenient digit value: 0-9 and A-F as usual, anything else relative to 'a'
  function automatic logic [7:0] digit_weight(input logic [7:0] c);
    logic [7:0] w;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      w = c - CH_ZERO;
    end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
      w = HEX_TEN + (c - CH_UPPER_A);
    end else begin
      w = HEX_TEN + (c - CH_LOWER_A);
    end
    return w;
  endfunction

  function automatic void clear_field();
    esc_phase   = ESC_NONE;
    high_nibble = '0;
    kept_count  = '0;
    field_dead  = 1'b0;
  endfunction

  // advance the field state by one input word and return its result word
  function automatic out_word_t url_decode_step(input in_word_t w);
    out_word_t  o;
    logic [7:0] c;
    logic [7:0] v;
    int         keep_limit;
    o = '0;
    c = w.char_in;
    keep_limit = (max_len_cfg < KEEP_CAP) ? int'(max_len_cfg) : KEEP_CAP;
    if (w.end_of_line || c == CH_NUL || c == stop_cfg) begin
      // field end flushes a cut-off escape
      o.field_end = 1'b1;
      if (!field_dead) begin
        if (esc_phase == ESC_PCT) begin
          o.out_byte   = CH_PERCENT;
          o.byte_valid = 1'b1;
        end else if (esc_phase == ESC_HIGH && high_nibble != 8'd0) begin
          o.out_byte   = high_nibble;
          o.byte_valid = 1'b1;
        end
      end
      clear_field();
    end else if (kept_count < keep_limit) begin
      kept_count = kept_count + 1'b1;
      if (!field_dead) begin
        if (c == CH_PLUS) begin
          c = CH_SPACE;
        end
        case (esc_phase)
          ESC_NONE: begin
            if (c == CH_PERCENT) begin
              esc_phase = ESC_PCT;
            end else begin
              o.out_byte   = c;
              o.byte_valid = 1'b1;
            end
          end
          ESC_PCT: begin
            high_nibble = digit_weight(c) << NIBBLE;
            esc_phase   = ESC_HIGH;
          end
          default: begin
            v           = high_nibble + digit_weight(c);
            esc_phase   = ESC_NONE;
            high_nibble = '0;
            if (v == 8'd0) begin
              field_dead = 1'b1;
            end else begin
              o.out_byte   = v;
              o.byte_valid = 1'b1;
            end
          end
        endcase
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= REPORT_LINES) begin
      $display("%0t result %0d: %s expected %0h got %0h", $realtime, results_seen, what,
               exp_v, got_v);
    end
  endtask

  // follow register writes, check result words, predict input words
  always @(posedge clk) begin
    if (rst) begin
      stop_cfg    = STOP_CHAR_RESET;
      max_len_cfg = MAX_LEN_RESET;
      clear_field();
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_CHAR: stop_cfg = cfg_data[7:0];
          REG_MAX_LEN:   max_len_cfg = cfg_data[MAX_LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("word with none pending, byte", 0, result.out_byte);
        end else begin
          want = decoded_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", want.out_byte, result.out_byte);
          end
          if (result.byte_valid !== want.byte_valid) begin
            report_mismatch("byte_valid", want.byte_valid, result.byte_valid);
          end
          if (result.field_end !== want.field_end) begin
            report_mismatch("field_end", want.field_end, result.field_end);
          end
        end
      end
      if (item_valid && item_ready) begin
        decoded_q.push_back(url_decode_step(item));
      end
    end
    pending = decoded_q.size();
  end

  // this block is empty; the testbench top treats a nonzero pending count as an error
  final begin
  end

endmodule

// ===== test/form_field_url_decoder_tb.sv =====
// testbench top for the form field url decoder: directed and random byte
// streams, register settings, random idling and one long output stall
// depends on ffud_pkg, form_field_url_decoder and ffud_decode_checker
module form_field_url_decoder_tb;
  import ffud_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         COUNT_BITS  = 10;
  localparam int         HOLD_CYCLES = 60;
  localparam int         STALL_LIMIT = 1000;
  localparam int         SETTLE      = 4;
  localparam logic [7:0] CH_NUL      = 8'h00;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     item_valid;
  logic                     item_ready;
  in_word_t                 item;
  logic                     result_valid;
  logic                     result_ready;
  out_word_t                result;

  int         mismatches;
  int         pending;
  int         results_seen;
  int         words_sent;
  int         settings_used;
  logic [7:0] cur_stop;
  bit         no_idle;
  bit         steady_send;
  bit         hold_req;

  form_field_url_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  ffud_decode_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) decode_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word and hold it until accepted, then maybe idle a burst
  task automatic send_word(input logic [7:0] ch, input logic eol);
    in_word_t w;
    w.char_in     = ch;
    w.end_of_line = eol;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    words_sent++;
    if (!no_idle && !steady_send && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_word(ch, 1'b0);
  endtask

  // any byte that neither ends a field nor opens an escape
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == cur_stop || c == CH_PERCENT);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return CH_ZERO + 8'(k);
    end else if (k < 16) begin
      return CH_UPPER_A + 8'(k - 10);
    end else begin
      return CH_LOWER_A + 8'(k - 16);
    end
  endfunction

  // one field of random tokens, closed by the stop character or end of line
  task automatic send_field(input int most_tokens);
    int n;
    int k;
    n = $urandom_range(0, most_tokens);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_char(plain_char());
        5: send_char(CH_PLUS);
        6, 7: begin
          send_char(CH_PERCENT);
          send_char(hex_char());
          send_char(hex_char());
        end
        8: begin
          send_char(CH_PERCENT);
          send_char(8'($urandom_range(0, 255)));
          send_char(8'($urandom_range(0, 255)));
        end
        default: begin
          // escape cut off by the field end
          send_char(CH_PERCENT);
          if ($urandom_range(0, 1) == 1) begin
            send_char(hex_char());
          end
          k = n;
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_char(cur_stop);
    end
  endtask

  // mostly well-formed fields, some raw noise
  task automatic random_words(input int budget);
    int stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end else begin
        send_field(8);
      end
    end
  endtask

  // wait for every predicted word, then write both registers
  task automatic start_phase(input logic [7:0] stop, input logic [MAX_LEN_BITS-1:0] keep);
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STOP_CHAR;
    cfg_data  <= CFG_DATA_BITS'(stop);
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_data  <= CFG_DATA_BITS'(keep);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_stop = stop;
    settings_used++;
  endtask

  // receiver: ready bursts, stall bursts, and one long hold-off on request
  initial begin
    result_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog: too long without any word moving
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int start_count;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_STOP_CHAR;
    cfg_data      = '0;
    item_valid    = 1'b0;
    item          = '0;
    words_sent    = 0;
    settings_used = 1;
    cur_stop      = STOP_CHAR_RESET;
    no_idle       = 1'b0;
    steady_send   = 1'b0;
    hold_req      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed fields at the reset settings
    send_char("a");
    send_char(CH_PLUS);
    send_char(CH_PERCENT); send_char("4"); send_char("1");
    send_char(CH_PERCENT); send_char("F"); send_char("f");
    // decoded zero, then a byte that is dropped
    send_char(CH_PERCENT); send_char("0"); send_char("0");
    send_char("q");
    send_char(cur_stop);
    // empty field
    send_char(cur_stop);
    // escape cut off by end of line and by a zero byte
    send_char(CH_PERCENT); send_char("7");
    send_word(8'hFF, 1'b1);
    send_char(CH_PERCENT);
    send_char(CH_NUL);
    // cut-off escape with a zero partial value
    send_char(CH_PERCENT); send_char("0");
    send_char(cur_stop);
    send_char(8'hFF);
    send_word(8'h00, 1'b1);

    // zero stop character, widest length, one field past the counter cap
    start_phase(CH_NUL, 10'd1023);
    repeat (1030) send_char(plain_char());
    send_word(8'($urandom_range(0, 255)), 1'b1);
    random_words(170);

    // nothing kept
    start_phase(8'hFF, 10'd0);
    random_words(100);

    // short fields, with the output held off while words keep coming
    start_phase("&", 10'd3);
    hold_req    = 1'b1;
    steady_send = 1'b1;
    start_count = words_sent;
    while (words_sent < start_count + 40) send_field(6);
    steady_send = 1'b0;
    random_words(100);

    // escape and plus characters as field separators
    start_phase(CH_PERCENT, 10'd1023);
    random_words(100);
    start_phase(CH_PLUS, 10'd7);
    random_words(100);

    start_phase(8'($urandom_range(0, 255)), 10'($urandom_range(0, 40)));
    random_words(100);
    start_phase(";", 10'd1);
    random_words(100);

    // last part without idling on either side
    start_phase(STOP_CHAR_RESET, MAX_LEN_RESET);
    no_idle = 1'b1;
    random_words(130);

    // drain
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d input words, checked %0d result words under %0d register settings",
             words_sent, results_seen, settings_used);
    $display("run covered escapes, plus signs, cut-off escapes, truncation and a long stall");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ffud_pkg.sv
rtl/ffud_core.sv
rtl/ffud_out_reg.sv
rtl/form_field_url_decoder.sv
test/ffud_decode_checker.sv
test/form_field_url_decoder_tb.sv
